[design/mic1_pkg.sv]
// Shared types, codes and constants of the Mic-1 datapath.
`timescale 1ns / 1ps

package mic1_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int CS_WORDS      = 512;
    localparam int CS_AW         = 9;
    localparam int MI_W          = 36;
    localparam int WORD_W        = 32;
    localparam int NUM_REGS      = 9;

    // C-bus register order
    localparam int REG_MAR = 0;
    localparam int REG_MDR = 1;
    localparam int REG_PC  = 2;
    localparam int REG_SP  = 3;
    localparam int REG_LV  = 4;
    localparam int REG_CPP = 5;
    localparam int REG_TOS = 6;
    localparam int REG_OPC = 7;
    localparam int REG_H   = 8;

    // item function codes
    localparam logic [1:0] FUNC_CS_WR  = 2'd0;
    localparam logic [1:0] FUNC_MEM_WR = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // B bus sources
    localparam logic [3:0] BSEL_MDR   = 4'd0;
    localparam logic [3:0] BSEL_PC    = 4'd1;
    localparam logic [3:0] BSEL_MBR_S = 4'd2;
    localparam logic [3:0] BSEL_MBR_U = 4'd3;
    localparam logic [3:0] BSEL_SP    = 4'd4;
    localparam logic [3:0] BSEL_LV    = 4'd5;
    localparam logic [3:0] BSEL_CPP   = 4'd6;
    localparam logic [3:0] BSEL_TOS   = 4'd7;
    localparam logic [3:0] BSEL_OPC   = 4'd8;

    // ALU function codes
    localparam logic [5:0] ALU_A         = 6'd24;
    localparam logic [5:0] ALU_B         = 6'd20;
    localparam logic [5:0] ALU_NOT_A     = 6'd26;
    localparam logic [5:0] ALU_NOT_B     = 6'd44;
    localparam logic [5:0] ALU_SUM       = 6'd60;
    localparam logic [5:0] ALU_SUM_INC   = 6'd61;
    localparam logic [5:0] ALU_A_INC     = 6'd57;
    localparam logic [5:0] ALU_B_INC     = 6'd53;
    localparam logic [5:0] ALU_B_SUB_A   = 6'd63;
    localparam logic [5:0] ALU_B_DEC     = 6'd54;
    localparam logic [5:0] ALU_NEG_A     = 6'd59;
    localparam logic [5:0] ALU_AND       = 6'd12;
    localparam logic [5:0] ALU_OR        = 6'd28;
    localparam logic [5:0] ALU_ZERO      = 6'd16;
    localparam logic [5:0] ALU_ONE       = 6'd49;
    localparam logic [5:0] ALU_MINUS_ONE = 6'd50;

    localparam logic [CS_AW-1:0] JAM_BIT = 9'h100;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEM,
        ST_RESULT
    } state_t;

    // microinstruction layout, MSB first
    typedef struct packed {
        logic [CS_AW-1:0]    next_addr;
        logic                jmpc;
        logic                jamn;
        logic                jamz;
        logic [1:0]          shift;
        logic [5:0]          alu;
        logic [NUM_REGS-1:0] c_en;
        logic                write;
        logic                read;
        logic                fetch;
        logic [3:0]          b_sel;
    } mi_t;

    typedef struct packed {
        logic [WORD_W-1:0] mdr;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] sp;
        logic [WORD_W-1:0] lv;
        logic [WORD_W-1:0] cpp;
        logic [WORD_W-1:0] tos;
        logic [WORD_W-1:0] opc;
        logic [WORD_W-1:0] h;
        logic [7:0]        mbr;
        logic [WORD_W-1:0] b_hold;
        logic [WORD_W-1:0] alu_prev;
    } dp_src_t;

    typedef struct packed {
        logic [WORD_W-1:0] b_bus;
        logic [WORD_W-1:0] alu_out;
        logic [WORD_W-1:0] c_bus;
    } dp_out_t;

endpackage

[design/mic1_microprogrammed_datapath_top.sv]
// Mic-1 datapath top: sequencer, register file, control store and main memory.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  cfg      | cfg_wr_en          | cfg_wr_data (shift field order)
//  s_ (in)  | s_valid / s_ready  | s_func, s_load_addr, s_load_data
//  m_ (out) | m_valid / m_ready  | m_next_mpc, m_c_bus, m_neg_flag, m_zero_flag
//
// A load item is done in the accept cycle if the output is free. For a tick the
// microinstruction at MPC is held pre-read from the control store, the datapath
// runs in the accept cycle and in ST_MEM, the state after it, the registered
// memory read returns and the next MPC is formed. A control store write holds
// s_ready low until the word at MPC has been re-read. After reset a clearing
// pass zeroes both memories before s_ready rises.
// A stalled output holds one result while the next item is accepted and run.
`timescale 1ns / 1ps

module mic1_microprogrammed_datapath_top #(
    parameter int MEM_BYTES = mic1_pkg::MEM_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [15:0]                  s_load_addr,
    input  logic [35:0]                  s_load_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [8:0]                   m_next_mpc,
    output logic [31:0]                  m_c_bus,
    output logic                         m_neg_flag,
    output logic                         m_zero_flag
);

    localparam int MEM_ROWS = MEM_BYTES / 4;
    localparam int ROW_W    = $clog2(MEM_ROWS);
    localparam int ADDR_W   = $clog2(MEM_BYTES);
    localparam int CLR_LEN  = (MEM_ROWS > mic1_pkg::CS_WORDS) ? MEM_ROWS : mic1_pkg::CS_WORDS;
    localparam int CLR_W    = $clog2(CLR_LEN);
    localparam int NREG     = mic1_pkg::NUM_REGS;
    localparam int CS_AW    = mic1_pkg::CS_AW;
    localparam int WW       = mic1_pkg::WORD_W;

    mic1_pkg::state_t state_reg, state_next;

    logic             shift_order_reg;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             cs_ok_reg;

    logic [WW-1:0]    wreg_reg [NREG];
    logic [WW-1:0]    wreg_next [NREG];
    logic [CS_AW-1:0] mpc_reg, mpc_next;
    logic [7:0]       mbr_reg, mbr_next;
    logic [WW-1:0]    alu_reg, alu_next;
    logic [WW-1:0]    b_hold_reg, b_hold_next;
    logic             flag_n_reg, flag_n_next;
    logic             flag_z_reg, flag_z_next;
    logic [WW-1:0]    cbus_hold_reg, cbus_hold_next;

    logic             m_valid_reg, m_valid_next;
    logic [CS_AW-1:0] m_next_mpc_reg;
    logic [WW-1:0]    m_c_bus_reg;
    logic             m_neg_flag_reg;
    logic             m_zero_flag_reg;

    logic accept, tick_go, load_go, mem_go, out_free, out_load, clr_last;
    logic clr_cs_en, clr_mem_en;
    logic s_ready_c;

    logic [mic1_pkg::MI_W-1:0] cs_q;
    mic1_pkg::mi_t             mi;
    mic1_pkg::dp_src_t         dp_src;
    mic1_pkg::dp_out_t         dp_res;

    logic                      cs_we;
    logic [CS_AW-1:0]          cs_wr_addr;
    logic [mic1_pkg::MI_W-1:0] cs_wr_data;
    logic [CS_AW-1:0]          cs_rd_addr;

    logic [3:0]       mem_lane_en;
    logic [ROW_W-1:0] mem_wr_row;
    logic [WW-1:0]    mem_wr_data;
    logic [WW-1:0]    mem_word_q;
    logic [7:0]       mem_byte_q;

    assign mi = mic1_pkg::mi_t'(cs_q);

    // ---- handshake decode ----
    assign out_free  = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready_c;
    assign tick_go   = accept && (s_func == mic1_pkg::FUNC_TICK);
    assign load_go   = accept && (s_func != mic1_pkg::FUNC_TICK);
    assign mem_go    = (state_reg == mic1_pkg::ST_MEM);
    assign clr_last  = (clr_cnt_reg == CLR_W'(CLR_LEN - 1));
    assign clr_cs_en = (state_reg == mic1_pkg::ST_CLEAR)
                       && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(mic1_pkg::CS_WORDS));
    assign clr_mem_en = (state_reg == mic1_pkg::ST_CLEAR)
                       && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(MEM_ROWS));

    // ---- sequencer: next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mic1_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = mic1_pkg::ST_IDLE;
                end
            end
            mic1_pkg::ST_IDLE: begin
                if (tick_go) begin
                    state_next = mic1_pkg::ST_MEM;
                end else if (load_go && !out_free) begin
                    state_next = mic1_pkg::ST_RESULT;
                end
            end
            mic1_pkg::ST_MEM: begin
                state_next = out_free ? mic1_pkg::ST_IDLE : mic1_pkg::ST_RESULT;
            end
            mic1_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = mic1_pkg::ST_IDLE;
                end
            end
            default: state_next = mic1_pkg::ST_CLEAR;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb begin
        s_ready_c    = 1'b0;
        out_load     = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            mic1_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            end
            mic1_pkg::ST_IDLE: begin
                s_ready_c = cs_ok_reg;
                out_load  = load_go && out_free;
            end
            mic1_pkg::ST_MEM: begin
                out_load = out_free;
            end
            mic1_pkg::ST_RESULT: begin
                out_load = out_free;
            end
            default: begin
                s_ready_c = 1'b0;
            end
        endcase
    end

    // ---- datapath next values ----
    always_comb begin
        logic [CS_AW-1:0] target;
        for (int i = 0; i < NREG; i++) begin
            wreg_next[i] = wreg_reg[i];
        end
        b_hold_next    = b_hold_reg;
        alu_next       = alu_reg;
        flag_n_next    = flag_n_reg;
        flag_z_next    = flag_z_reg;
        mbr_next       = mbr_reg;
        cbus_hold_next = cbus_hold_reg;
        mpc_next       = mpc_reg;
        target         = mi.next_addr;

        if (tick_go) begin
            b_hold_next    = dp_res.b_bus;
            alu_next       = dp_res.alu_out;
            flag_n_next    = dp_res.alu_out[WW-1];
            flag_z_next    = (dp_res.alu_out == '0);
            cbus_hold_next = dp_res.c_bus;
            for (int i = 0; i < NREG; i++) begin
                if (mi.c_en[i]) begin
                    wreg_next[i] = dp_res.c_bus;
                end
            end
        end else if (load_go) begin
            cbus_hold_next = '0;
        end

        // ST_MEM of a tick: memory data is back
        if (mem_go) begin
            if (mi.read) begin
                wreg_next[mic1_pkg::REG_MDR] = mem_word_q;
            end
            if (mi.fetch) begin
                mbr_next = mem_byte_q;
            end
            if (mi.jmpc) begin
                target = target | {1'b0, mbr_next};
            end
            if ((mi.jamn && flag_n_reg) || (mi.jamz && flag_z_reg)) begin
                target = target | mic1_pkg::JAM_BIT;
            end
            mpc_next = target;
        end
    end

    assign dp_src.mdr      = wreg_reg[mic1_pkg::REG_MDR];
    assign dp_src.pc       = wreg_reg[mic1_pkg::REG_PC];
    assign dp_src.sp       = wreg_reg[mic1_pkg::REG_SP];
    assign dp_src.lv       = wreg_reg[mic1_pkg::REG_LV];
    assign dp_src.cpp      = wreg_reg[mic1_pkg::REG_CPP];
    assign dp_src.tos      = wreg_reg[mic1_pkg::REG_TOS];
    assign dp_src.opc      = wreg_reg[mic1_pkg::REG_OPC];
    assign dp_src.h        = wreg_reg[mic1_pkg::REG_H];
    assign dp_src.mbr      = mbr_reg;
    assign dp_src.b_hold   = b_hold_reg;
    assign dp_src.alu_prev = alu_reg;

    mic1_exec u_exec (
        .mi          (mi),
        .src         (dp_src),
        .shift_order (shift_order_reg),
        .res         (dp_res)
    );

    // ---- control store ports ----
    always_comb begin
        cs_we      = 1'b0;
        cs_wr_addr = s_load_addr[CS_AW-1:0];
        cs_wr_data = s_load_data;
        if (clr_cs_en) begin
            cs_we      = 1'b1;
            cs_wr_addr = clr_cnt_reg[CS_AW-1:0];
            cs_wr_data = '0;
        end else if (load_go && (s_func == mic1_pkg::FUNC_CS_WR)) begin
            cs_we = 1'b1;
        end
    end

    // keep the word at the coming MPC pre-read
    assign cs_rd_addr = mem_go ? mpc_next : mpc_reg;

    mic1_ctl_store u_cs (
        .aclk    (aclk),
        .wr_en   (cs_we),
        .wr_addr (cs_wr_addr),
        .wr_data (cs_wr_data),
        .rd_addr (cs_rd_addr),
        .rd_q    (cs_q)
    );

    // ---- main memory ports ----
    always_comb begin
        mem_lane_en = 4'b0000;
        mem_wr_row  = s_load_addr[ADDR_W-1:2];
        mem_wr_data = {4{s_load_data[7:0]}};
        if (clr_mem_en) begin
            mem_lane_en = 4'b1111;
            mem_wr_row  = clr_cnt_reg[ROW_W-1:0];
            mem_wr_data = '0;
        end else if (tick_go && mi.write && !mi.read) begin
            // a write with read also set is dropped: memory is left unchanged
            mem_lane_en = 4'b1111;
            mem_wr_row  = wreg_next[mic1_pkg::REG_MAR][ROW_W-1:0];
            mem_wr_data = wreg_next[mic1_pkg::REG_MDR];
        end else if (load_go && (s_func == mic1_pkg::FUNC_MEM_WR)) begin
            mem_lane_en = 4'b0001 << s_load_addr[1:0];
        end
    end

    mic1_main_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .aclk       (aclk),
        .wr_lane_en (mem_lane_en),
        .wr_row     (mem_wr_row),
        .wr_data    (mem_wr_data),
        .rd_row     (wreg_next[mic1_pkg::REG_MAR][ROW_W-1:0]),
        .fetch_addr (wreg_next[mic1_pkg::REG_PC][ADDR_W-1:0]),
        .word_q     (mem_word_q),
        .byte_q     (mem_byte_q)
    );

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // ---- control and architectural state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mic1_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            cs_ok_reg       <= 1'b0;
            shift_order_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NREG; i++) begin
                wreg_reg[i] <= '0;
            end
            mpc_reg    <= '0;
            mbr_reg    <= '0;
            alu_reg    <= '0;
            b_hold_reg <= '0;
            flag_n_reg <= 1'b0;
            flag_z_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cs_ok_reg   <= !cs_we;
            if (cfg_wr_en) begin
                shift_order_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NREG; i++) begin
                wreg_reg[i] <= wreg_next[i];
            end
            mpc_reg    <= mpc_next;
            mbr_reg    <= mbr_next;
            alu_reg    <= alu_next;
            b_hold_reg <= b_hold_next;
            flag_n_reg <= flag_n_next;
            flag_z_reg <= flag_z_next;
        end
    end

    // ---- payload ----
    always_ff @(posedge aclk) begin
        cbus_hold_reg <= cbus_hold_next;
        if (out_load) begin
            m_next_mpc_reg  <= mpc_next;
            m_c_bus_reg     <= cbus_hold_next;
            m_neg_flag_reg  <= flag_n_next;
            m_zero_flag_reg <= flag_z_next;
        end
    end

    assign s_ready     = s_ready_c;
    assign m_valid     = m_valid_reg;
    assign m_next_mpc  = m_next_mpc_reg;
    assign m_c_bus     = m_c_bus_reg;
    assign m_neg_flag  = m_neg_flag_reg;
    assign m_zero_flag = m_zero_flag_reg;

    // ---- assertions ----
    a_tick_to_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == mic1_pkg::FUNC_TICK))
        |=> (state_reg == mic1_pkg::ST_MEM))
        else $error("tick item did not advance to memory cycle");

    a_mpc_held_for_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mic1_pkg::ST_MEM) |-> $stable(mpc_reg))
        else $error("MPC moved between control store read and memory cycle");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

    a_cs_write_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == mic1_pkg::FUNC_CS_WR)) |=> !s_ready)
        else $error("item accepted before control store word was re-read");

endmodule

[design/mic1_ctl_store.sv]
// Control store: 512 microinstruction words, one write and one registered read port.
`timescale 1ns / 1ps

module mic1_ctl_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [mic1_pkg::CS_AW-1:0]   wr_addr,
    input  logic [mic1_pkg::MI_W-1:0]    wr_data,
    input  logic [mic1_pkg::CS_AW-1:0]   rd_addr,
    output logic [mic1_pkg::MI_W-1:0]    rd_q
);

    logic [mic1_pkg::MI_W-1:0] cs_mem [mic1_pkg::CS_WORDS];
    logic [mic1_pkg::MI_W-1:0] rd_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cs_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= cs_mem[rd_addr];
    end

    assign rd_q = rd_q_reg;

endmodule

[design/mic1_main_mem.sv]
// Main memory: four byte lanes, one write port, word read and byte fetch read ports.
`timescale 1ns / 1ps

module mic1_main_mem #(
    parameter  int MEM_BYTES = mic1_pkg::MEM_BYTES_DEF,
    localparam int MEM_ROWS  = MEM_BYTES / 4,
    localparam int ROW_W     = $clog2(MEM_ROWS),
    localparam int ADDR_W    = $clog2(MEM_BYTES)
) (
    input  logic                        aclk,
    input  logic [3:0]                  wr_lane_en,
    input  logic [ROW_W-1:0]            wr_row,
    input  logic [mic1_pkg::WORD_W-1:0] wr_data,
    input  logic [ROW_W-1:0]            rd_row,
    input  logic [ADDR_W-1:0]           fetch_addr,
    output logic [mic1_pkg::WORD_W-1:0] word_q,
    output logic [7:0]                  byte_q
);

    localparam int LANES = 4;

    logic [7:0]                  mem_arr [LANES][MEM_ROWS];
    logic [mic1_pkg::WORD_W-1:0] word_q_reg;
    logic [mic1_pkg::WORD_W-1:0] fetch_q_reg;
    logic [1:0]                  fetch_lane_reg;
    logic [ROW_W-1:0]            fetch_row;

    assign fetch_row = fetch_addr[ADDR_W-1:2];

    // reads see the contents from before a write at the same edge
    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (wr_lane_en[l]) begin
                mem_arr[l][wr_row] <= wr_data[8*l +: 8];
            end
            word_q_reg[8*l +: 8]  <= mem_arr[l][rd_row];
            fetch_q_reg[8*l +: 8] <= mem_arr[l][fetch_row];
        end
        fetch_lane_reg <= fetch_addr[1:0];
    end

    assign word_q = word_q_reg;
    assign byte_q = fetch_q_reg[8*fetch_lane_reg +: 8];

endmodule

[design/mic1_exec.sv]
// B bus select, ALU and shifter for one microinstruction.
`timescale 1ns / 1ps

module mic1_exec (
    input  mic1_pkg::mi_t     mi,
    input  mic1_pkg::dp_src_t src,
    input  logic              shift_order,
    output mic1_pkg::dp_out_t res
);

    logic [mic1_pkg::WORD_W-1:0] b_bus;
    logic [mic1_pkg::WORD_W-1:0] alu_out;
    logic [mic1_pkg::WORD_W-1:0] sh_out;
    logic                        do_sll;
    logic                        do_sra;

    always_comb begin
        case (mi.b_sel)
            mic1_pkg::BSEL_MDR:   b_bus = src.mdr;
            mic1_pkg::BSEL_PC:    b_bus = src.pc;
            mic1_pkg::BSEL_MBR_S: b_bus = {{24{src.mbr[7]}}, src.mbr};
            mic1_pkg::BSEL_MBR_U: b_bus = {24'd0, src.mbr};
            mic1_pkg::BSEL_SP:    b_bus = src.sp;
            mic1_pkg::BSEL_LV:    b_bus = src.lv;
            mic1_pkg::BSEL_CPP:   b_bus = src.cpp;
            mic1_pkg::BSEL_TOS:   b_bus = src.tos;
            mic1_pkg::BSEL_OPC:   b_bus = src.opc;
            default:              b_bus = src.b_hold;
        endcase
    end

    always_comb begin
        case (mi.alu)
            mic1_pkg::ALU_A:         alu_out = src.h;
            mic1_pkg::ALU_B:         alu_out = b_bus;
            mic1_pkg::ALU_NOT_A:     alu_out = ~src.h;
            mic1_pkg::ALU_NOT_B:     alu_out = ~b_bus;
            mic1_pkg::ALU_SUM:       alu_out = src.h + b_bus;
            mic1_pkg::ALU_SUM_INC:   alu_out = src.h + b_bus + 32'd1;
            mic1_pkg::ALU_A_INC:     alu_out = src.h + 32'd1;
            mic1_pkg::ALU_B_INC:     alu_out = b_bus + 32'd1;
            mic1_pkg::ALU_B_SUB_A:   alu_out = b_bus - src.h;
            mic1_pkg::ALU_B_DEC:     alu_out = b_bus - 32'd1;
            mic1_pkg::ALU_NEG_A:     alu_out = 32'd0 - src.h;
            mic1_pkg::ALU_AND:       alu_out = src.h & b_bus;
            mic1_pkg::ALU_OR:        alu_out = src.h | b_bus;
            mic1_pkg::ALU_ZERO:      alu_out = 32'd0;
            mic1_pkg::ALU_ONE:       alu_out = 32'd1;
            mic1_pkg::ALU_MINUS_ONE: alu_out = 32'hFFFF_FFFF;
            default:                 alu_out = src.alu_prev;
        endcase
    end

    assign do_sll = shift_order ? mi.shift[0] : mi.shift[1];
    assign do_sra = shift_order ? mi.shift[1] : mi.shift[0];

    // both or neither shift bit: pass through
    always_comb begin
        if (do_sll && !do_sra) begin
            sh_out = {alu_out[23:0], 8'd0};
        end else if (do_sra && !do_sll) begin
            sh_out = {alu_out[31], alu_out[31:1]};
        end else begin
            sh_out = alu_out;
        end
    end

    assign res.b_bus   = b_bus;
    assign res.alu_out = alu_out;
    assign res.c_bus   = sh_out;

endmodule
